// ===== rtl/ilao_pkg.sv =====
// Shared types and constants for the interval list intersection/union merger.
// Used by ilao_cmp and interval_list_and_or; depends on nothing else.
`default_nettype none

package ilao_pkg;

	// Endpoint width and the cap on result words per merge.
	localparam int EP_W        = 16;
	localparam int MAX_RESULTS = 32;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// Input word kinds.
	localparam logic [1:0] KIND_LOAD_A = 2'd0;
	localparam logic [1:0] KIND_LOAD_B = 2'd1;
	localparam logic [1:0] KIND_MERGE  = 2'd2;

	// Mode register values.
	localparam logic MODE_INTERSECT = 1'b0;
	localparam logic MODE_UNION     = 1'b1;

	// One stored interval: start in the low half, end in the high half.
	typedef struct packed {
		logic signed [EP_W-1:0] hi;
		logic signed [EP_W-1:0] lo;
	} interval_t;

	// Compare results of the current A and B entries against each other
	// and against the running upper end of a fused union run.
	typedef struct packed {
		logic b_before_a;   // B ends before A starts
		logic a_before_b;   // A ends before B starts
		logic a_end_lt_b;   // A ends before B ends
		logic a_start_gt_b; // A starts after B starts
		logic a_past_hi;    // A starts after the running upper end
		logic b_past_hi;    // B starts after the running upper end
	} cmp_flags_t;

endpackage

`default_nettype wire

// ===== rtl/interval_list_and_or.sv =====
// Top level of the sorted interval list intersection/union merger.
// Depends on ilao_pkg, ilao_ram (one per list) and ilao_cmp.
`default_nettype none

// How to use this block:
// An input word is taken at a rising edge where start is high and busy is
// low. A word of kind load A or load B appends one interval to its list in
// that same cycle; a list that is already full drops the interval and
// records an overflow. Busy stays low, so loads stream at one per cycle.
// A merge word walks both lists with two read pointers. Busy rises on the
// next cycle and stays high for the whole walk. Each pointer step waits
// for a list RAM read (S_READ) and then makes a pass through the compare
// unit; a fused union run adds an S_CHK check for each absorbed interval,
// and the RAM read latency sets the pace of the walk.
// Result words appear on out_start/out_end with a one-cycle out_valid strobe.
// The receiver cannot hold them off; each word is presented exactly once.
// The final word of a merge carries is_last, and busy is low in that cycle.
// An empty result gives one word with is_empty set and zero endpoints.
// At most MAX_RESULTS words are produced; extra ones are dropped.
// After a merge both lists and the overflow record are cleared.
// The mode register (0 intersect, 1 union) is written through cfg_valid and
// cfg_ready; cfg_ready is low while a merge runs.
// Reset clears both list counts, the overflow record and the mode; the list
// RAM contents are not cleared and are never read beyond the counts.

module interval_list_and_or #(
	parameter int MAX_INTERVALS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Command channel.
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] start_point,
	input  wire logic signed [15:0] end_point,
	// Mode register write channel.
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_data,
	// Result channel.
	output logic                    out_valid,
	output logic signed [15:0]      out_start,
	output logic signed [15:0]      out_end,
	output logic                    is_empty,
	output logic                    overflowed,
	output logic                    is_last
);

	import ilao_pkg::*;

	localparam int ADDR_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int PTR_W  = $clog2(MAX_INTERVALS + 1);
	localparam logic [PTR_W-1:0] LIST_FULL = PTR_W'(MAX_INTERVALS);
	localparam logic [RES_CNT_W-1:0] RES_CAP = RES_CNT_W'(MAX_RESULTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_HEAD,
		S_FUSE,
		S_CHK,
		S_TAIL_A,
		S_TAIL_B,
		S_DONE
	} state_t;

	state_t                 state_q, state_d;
	state_t                 ret_q, ret_d;
	logic [PTR_W-1:0]       cnt_a_q, cnt_b_q;
	logic [PTR_W-1:0]       ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
	logic [PTR_W-1:0]       ptr_a_inc, ptr_b_inc;
	logic                   ovf_q;
	logic                   mode_q;
	logic signed [EP_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic                   side_a_q, side_a_d;
	logic [RES_CNT_W-1:0]   emit_cnt_q;
	logic                   pend_valid_q;
	interval_t              pend_q;
	logic                   emit_req;
	interval_t              emit_val;

	logic                   cmd_acc;
	logic                   we_a, we_b;
	logic [2*EP_W-1:0]      rd_a, rd_b;
	interval_t              cur_a, cur_b;
	cmp_flags_t             flags;
	logic                   a_live, b_live, is_union;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign cmd_acc   = start && !busy;

	assign we_a = cmd_acc && (kind == KIND_LOAD_A) && (cnt_a_q < LIST_FULL);
	assign we_b = cmd_acc && (kind == KIND_LOAD_B) && (cnt_b_q < LIST_FULL);

	// The read address follows the pointer, so the entry under each pointer
	// is available in the cycle after the pointer moves.
	ilao_ram #(
		.WIDTH (2*EP_W),
		.DEPTH (MAX_INTERVALS)
	) u_list_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[ADDR_W-1:0]),
		.wdata ({end_point, start_point}),
		.raddr (ptr_a_q[ADDR_W-1:0]),
		.rdata (rd_a)
	);

	ilao_ram #(
		.WIDTH (2*EP_W),
		.DEPTH (MAX_INTERVALS)
	) u_list_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[ADDR_W-1:0]),
		.wdata ({end_point, start_point}),
		.raddr (ptr_b_q[ADDR_W-1:0]),
		.rdata (rd_b)
	);

	assign cur_a = interval_t'(rd_a);
	assign cur_b = interval_t'(rd_b);

	ilao_cmp u_cmp (
		.entry_a (cur_a),
		.entry_b (cur_b),
		.run_hi  (hi_q),
		.flags   (flags)
	);

	assign a_live    = ptr_a_q < cnt_a_q;
	assign b_live    = ptr_b_q < cnt_b_q;
	assign ptr_a_inc = ptr_a_q + PTR_W'(1);
	assign ptr_b_inc = ptr_b_q + PTR_W'(1);
	assign is_union  = (mode_q == MODE_UNION);

	// Walk sequencer: decides the next pointer move and any result to emit.
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		ptr_a_d  = ptr_a_q;
		ptr_b_d  = ptr_b_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		side_a_d = side_a_q;
		emit_req = 1'b0;
		emit_val = cur_a;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc && (kind == KIND_MERGE)) begin
					ptr_a_d = '0;
					ptr_b_d = '0;
					state_d = S_READ;
					ret_d   = S_HEAD;
				end
			end
			S_READ: begin
				state_d = ret_q;
			end
			S_HEAD: begin
				state_d = S_READ;
				ret_d   = S_HEAD;
				if (!(a_live && b_live)) begin
					// One list is used up; union passes the rest through.
					if (is_union && a_live) begin
						ret_d = S_TAIL_A;
					end else if (is_union && b_live) begin
						ret_d = S_TAIL_B;
					end else begin
						state_d = S_DONE;
					end
				end else if (flags.b_before_a) begin
					ptr_b_d  = ptr_b_inc;
					emit_req = is_union;
					emit_val = cur_b;
				end else if (flags.a_before_b) begin
					ptr_a_d  = ptr_a_inc;
					emit_req = is_union;
					emit_val = cur_a;
				end else if (!is_union) begin
					emit_req    = 1'b1;
					emit_val.lo = flags.a_start_gt_b ? cur_a.lo : cur_b.lo;
					emit_val.hi = flags.a_end_lt_b ? cur_a.hi : cur_b.hi;
					if (flags.a_end_lt_b) begin
						ptr_a_d = ptr_a_inc;
					end else begin
						ptr_b_d = ptr_b_inc;
					end
				end else begin
					// Overlap in union mode opens a fused run at the lower start.
					lo_d    = flags.a_start_gt_b ? cur_b.lo : cur_a.lo;
					state_d = S_FUSE;
				end
			end
			S_FUSE: begin
				state_d     = S_READ;
				emit_val.lo = lo_q;
				if (flags.a_end_lt_b) begin
					hi_d     = cur_b.hi;
					emit_val.hi = cur_b.hi;
					ptr_a_d  = ptr_a_inc;
					side_a_d = 1'b1;
					if (ptr_a_inc >= cnt_a_q) begin
						ptr_b_d  = ptr_b_inc;
						emit_req = 1'b1;
						ret_d    = S_HEAD;
					end else begin
						ret_d = S_CHK;
					end
				end else begin
					hi_d     = cur_a.hi;
					emit_val.hi = cur_a.hi;
					ptr_b_d  = ptr_b_inc;
					side_a_d = 1'b0;
					if (ptr_b_inc >= cnt_b_q) begin
						ptr_a_d  = ptr_a_inc;
						emit_req = 1'b1;
						ret_d    = S_HEAD;
					end else begin
						ret_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				// The advanced list's next start decides whether the run goes on.
				emit_val.lo = lo_q;
				emit_val.hi = hi_q;
				if (side_a_q ? flags.a_past_hi : flags.b_past_hi) begin
					emit_req = 1'b1;
					if (side_a_q) begin
						ptr_b_d = ptr_b_inc;
					end else begin
						ptr_a_d = ptr_a_inc;
					end
					state_d = S_READ;
					ret_d   = S_HEAD;
				end else begin
					state_d = S_FUSE;
				end
			end
			S_TAIL_A: begin
				emit_req = 1'b1;
				emit_val = cur_a;
				ptr_a_d  = ptr_a_inc;
				state_d  = S_READ;
				if (ptr_a_inc < cnt_a_q) begin
					ret_d = S_TAIL_A;
				end else if (b_live) begin
					ret_d = S_TAIL_B;
				end else begin
					state_d = S_DONE;
				end
			end
			S_TAIL_B: begin
				emit_req = 1'b1;
				emit_val = cur_b;
				ptr_b_d  = ptr_b_inc;
				if (ptr_b_inc < cnt_b_q) begin
					state_d = S_READ;
					ret_d   = S_TAIL_B;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, list counts and the result register. Each emitted interval is
	// held back one step so that the final one can carry the last mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_HEAD;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			ptr_a_q      <= '0;
			ptr_b_q      <= '0;
			ovf_q        <= 1'b0;
			mode_q       <= MODE_INTERSECT;
			lo_q         <= '0;
			hi_q         <= '0;
			side_a_q     <= 1'b0;
			emit_cnt_q   <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid    <= 1'b0;
			out_start    <= '0;
			out_end      <= '0;
			is_empty     <= 1'b0;
			overflowed   <= 1'b0;
			is_last      <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			ptr_a_q   <= ptr_a_d;
			ptr_b_q   <= ptr_b_d;
			lo_q      <= lo_d;
			hi_q      <= hi_d;
			side_a_q  <= side_a_d;
			out_valid <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end

			if (we_a) begin
				cnt_a_q <= cnt_a_q + PTR_W'(1);
			end
			if (we_b) begin
				cnt_b_q <= cnt_b_q + PTR_W'(1);
			end
			if (cmd_acc && !we_a && !we_b
					&& (kind == KIND_LOAD_A || kind == KIND_LOAD_B)) begin
				ovf_q <= 1'b1;
			end

			if (emit_req && (emit_cnt_q < RES_CAP)) begin
				emit_cnt_q   <= emit_cnt_q + RES_CNT_W'(1);
				pend_q       <= emit_val;
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid  <= 1'b1;
					out_start  <= pend_q.lo;
					out_end    <= pend_q.hi;
					is_empty   <= 1'b0;
					overflowed <= ovf_q;
					is_last    <= 1'b0;
				end
			end

			if (state_q == S_DONE) begin
				out_valid    <= 1'b1;
				out_start    <= pend_valid_q ? pend_q.lo : '0;
				out_end      <= pend_valid_q ? pend_q.hi : '0;
				is_empty     <= !pend_valid_q;
				overflowed   <= ovf_q;
				is_last      <= 1'b1;
				pend_valid_q <= 1'b0;
				emit_cnt_q   <= '0;
				cnt_a_q      <= '0;
				cnt_b_q      <= '0;
				ovf_q        <= 1'b0;
			end
		end
	end

	// The last word of a merge leaves as the block goes idle.
	a_last_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> !busy)
		else $error("last result word while the merge is still running");

	// An empty result is always the only, and so the last, word.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> is_last)
		else $error("empty result word without the last mark");

	// Read pointers never run past the loaded entries.
	a_ptr_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (ptr_a_q <= cnt_a_q) && (ptr_b_q <= cnt_b_q))
		else $error("list read pointer beyond its count");

	// List counts stay within the RAM depth.
	a_cnt_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= LIST_FULL) && (cnt_b_q <= LIST_FULL))
		else $error("list count beyond capacity");

	// A merge is followed by cleared lists and overflow record.
	a_clear_after_merge: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q)
		else $error("lists not cleared after a merge");

endmodule

`default_nettype wire

// ===== rtl/ilao_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds one interval list of the merger.
`default_nettype none

module ilao_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ilao_cmp.sv =====
// Shared compare unit of the merger: all endpoint comparisons of one walk step.
// Depends on ilao_pkg for the interval and flag types.
`default_nettype none

module ilao_cmp (
	input  wire ilao_pkg::interval_t          entry_a,
	input  wire ilao_pkg::interval_t          entry_b,
	input  wire logic signed [ilao_pkg::EP_W-1:0] run_hi,
	output ilao_pkg::cmp_flags_t              flags
);

	import ilao_pkg::*;

	always_comb begin
		flags.b_before_a   = entry_b.hi < entry_a.lo;
		flags.a_before_b   = entry_a.hi < entry_b.lo;
		flags.a_end_lt_b   = entry_a.hi < entry_b.hi;
		flags.a_start_gt_b = entry_a.lo > entry_b.lo;
		flags.a_past_hi    = entry_a.lo > run_hi;
		flags.b_past_hi    = entry_b.lo > run_hi;
	end

endmodule

`default_nettype wire
